FILE: design/lmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_pkg
// shared types and constants of the led mask framer
// ----------------------------------------------------------------------------
package lmf_pkg;

	localparam int START_BYTES = 4;
	localparam int MAX_RESULTS = 40;

	localparam logic [7:0] LED_HEADER = 8'hE0;
	localparam logic [7:0] END_BYTE   = 8'hFF;
	localparam logic [7:0] SET_CODE   = 8'h01;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_BLANK = 2'd2;

	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_BLUE       = 2'd1;
	localparam logic [1:0] REG_GREEN      = 2'd2;
	localparam logic [1:0] REG_RED        = 2'd3;

	localparam logic [1:0] PART_HEADER = 2'd0;
	localparam logic [1:0] PART_BLUE   = 2'd1;
	localparam logic [1:0] PART_GREEN  = 2'd2;
	localparam logic [1:0] PART_RED    = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_FRAME = 2'd2
	} lmf_op_t;

	typedef struct packed {
		logic [4:0] brightness;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} lmf_cfg_t;

	typedef struct packed {
		logic       valid;
		lmf_op_t    op;
		logic [7:0] mask;
		logic [7:0] rv;
	} lmf_item_t;

endpackage
`default_nettype wire

FILE: design/lmf_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_decode
// input register stage: keeps the led mask and, while in_stall is low, decodes one access per cycle
// ----------------------------------------------------------------------------
module lmf_decode
	import lmf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [1:0] func,
	input  wire logic [3:0] led_select,
	input  wire logic [7:0] write_data,
	input  wire logic       take,
	output      lmf_item_t  item
);

	logic       valid_s1;
	lmf_op_t    op_s1;
	logic [7:0] mask_s1;
	logic [7:0] rv_s1;
	logic [7:0] mask_q;
	logic [7:0] mask_next;
	logic [7:0] rv_next;
	logic [7:0] bit_sel;
	logic [2:0] bit_pos;
	logic       sel_bit;
	logic       accept;

	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;
	assign bit_pos  = 3'(led_select - 4'd1);
	assign sel_bit  = (led_select != 4'd0) && (led_select <= 4'd8);
	assign bit_sel  = 8'd1 << bit_pos;

	always_comb begin
		mask_next = mask_q;
		if (func == FUNC_WRITE) begin
			if (led_select == 4'd0) begin
				mask_next = write_data;
			end else if (sel_bit) begin
				if (write_data == SET_CODE) begin
					mask_next = mask_q | bit_sel;
				end else begin
					mask_next = mask_q ^ bit_sel;
				end
			end
		end
	end

	always_comb begin
		if (led_select == 4'd0) begin
			rv_next = mask_q;
		end else if (sel_bit) begin
			rv_next = {7'd0, mask_q[bit_pos]};
		end else begin
			rv_next = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mask_q   <= 8'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				mask_q   <= mask_next;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rv_s1 <= rv_next;
			case (func)
				FUNC_READ: begin
					op_s1   <= OP_READ;
					mask_s1 <= 8'd0;
				end
				FUNC_WRITE: begin
					op_s1   <= OP_FRAME;
					mask_s1 <= mask_next;
				end
				FUNC_BLANK: begin
					op_s1   <= OP_FRAME;
					mask_s1 <= 8'd0;
				end
				default: begin
					op_s1   <= OP_NONE;
					mask_s1 <= 8'd0;
				end
			endcase
		end
	end

	assign item = '{valid: valid_s1, op: op_s1, mask: mask_s1, rv: rv_s1};

endmodule
`default_nettype wire

FILE: design/lmf_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_emitter
// output stage: walks one frame byte per transfer, or gives one read reply
// ----------------------------------------------------------------------------
module lmf_emitter
	import lmf_pkg::*;
#(
	parameter int LED_COUNT = 8,
	parameter int END_BYTES = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lmf_item_t  item,
	input  wire lmf_cfg_t   cfg,
	output      logic       take,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic       is_frame_byte,
	output      logic [7:0] frame_byte,
	output      logic [7:0] read_value,
	output      logic       last
);

	localparam int RAW_LEN   = START_BYTES + 4 * LED_COUNT + END_BYTES;
	localparam int FRAME_LEN = (RAW_LEN < MAX_RESULTS) ? RAW_LEN : MAX_RESULTS;
	localparam int IDX_W     = $clog2(FRAME_LEN);
	localparam int LED_END   = START_BYTES + 4 * LED_COUNT;

	logic             busy_q;
	logic             rd_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       mask_q;
	logic [7:0]       rv_q;
	logic [IDX_W-1:0] rel;
	logic [IDX_W-1:0] led_num;
	logic             lit;
	logic [7:0]       byte_val;
	logic             done;
	logic             xfer;
	logic             free;

	assign xfer = busy_q && !out_stall;
	assign done = rd_q || (idx_q == IDX_W'(FRAME_LEN - 1));
	assign free = !busy_q || (xfer && done);
	assign take = item.valid && (free || item.op == OP_NONE);

	assign rel     = idx_q - IDX_W'(START_BYTES);
	assign led_num = IDX_W'(LED_COUNT - 1) - (rel >> 2);
	assign lit     = mask_q[led_num[2:0]];

	always_comb begin
		if (idx_q < IDX_W'(START_BYTES)) begin
			byte_val = 8'd0;
		end else if (idx_q < IDX_W'(LED_END)) begin
			case (rel[1:0])
				PART_HEADER: byte_val = lit ? (LED_HEADER | {3'd0, cfg.brightness}) : LED_HEADER;
				PART_BLUE:   byte_val = lit ? cfg.blue : 8'd0;
				PART_GREEN:  byte_val = lit ? cfg.green : 8'd0;
				PART_RED:    byte_val = lit ? cfg.red : 8'd0;
				default:     byte_val = 8'd0;
			endcase
		end else begin
			byte_val = END_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (free) begin
				busy_q <= take && (item.op != OP_NONE);
				idx_q  <= '0;
			end else if (xfer) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free && take) begin
			rd_q   <= (item.op == OP_READ);
			mask_q <= item.mask;
			rv_q   <= item.rv;
		end
	end

	assign out_valid     = busy_q;
	assign is_frame_byte = !rd_q;
	assign frame_byte    = rd_q ? 8'd0 : byte_val;
	assign read_value    = rd_q ? rv_q : 8'd0;
	assign last          = done;

endmodule
`default_nettype wire

FILE: design/led_mask_apa102_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_mask_apa102_framer
// led on/off mask register with an apa102 frame encoder
// ----------------------------------------------------------------------------
// A read access gives one reply transfer; a write or blank access gives one
// apa102 frame of 4 + 4*LED_COUNT + END_BYTES bytes, at most 40 (40 with the
// defaults), one byte per cycle from the output stage while out_stall is low.
// The next access is decoded while the current frame drains and follows
// without a gap. Color registers are read live by the output stage; the user
// must write them only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module led_mask_apa102_framer
	import lmf_pkg::*;
#(
	parameter int LED_COUNT = 8,
	parameter int END_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [3:0]  led_select,
	input  wire logic [7:0]  write_data,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        is_frame_byte,
	output      logic [7:0]  frame_byte,
	output      logic [7:0]  read_value,
	output      logic        last
);

	lmf_cfg_t   cfg_q;
	lmf_item_t  item;
	logic       take;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness <= 5'd20;
			cfg_q.blue       <= 8'd255;
			cfg_q.green      <= 8'd0;
			cfg_q.red        <= 8'd0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BRIGHTNESS: cfg_q.brightness <= pwdata[4:0];
				REG_BLUE:       cfg_q.blue       <= pwdata[7:0];
				REG_GREEN:      cfg_q.green      <= pwdata[7:0];
				REG_RED:        cfg_q.red        <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BRIGHTNESS: prdata = {27'd0, cfg_q.brightness};
			REG_BLUE:       prdata = {24'd0, cfg_q.blue};
			REG_GREEN:      prdata = {24'd0, cfg_q.green};
			REG_RED:        prdata = {24'd0, cfg_q.red};
			default:        prdata = 32'd0;
		endcase
	end

	lmf_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.led_select (led_select),
		.write_data (write_data),
		.take       (take),
		.item       (item)
	);

	lmf_emitter #(
		.LED_COUNT (LED_COUNT),
		.END_BYTES (END_BYTES)
	) u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cfg           (cfg_q),
		.take          (take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_frame_byte (is_frame_byte),
		.frame_byte    (frame_byte),
		.read_value    (read_value),
		.last          (last)
	);

endmodule
`default_nettype wire

FILE: sim/lmf_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_tb_pkg
// Scoreboard for the led mask framer. It keeps its own copy of the led mask
// and the lit color, turns every accepted read, write or blank access into the reply or the apa102
// frame it must produce, and checks the output transfers against them in order.
// ----------------------------------------------------------------------------
package lmf_tb_pkg;

	import lmf_pkg::*;

	localparam int STRIP_LEDS = 8;
	localparam int TAIL_BYTES = 4;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic       frame;
		logic [7:0] fbyte;
		logic [7:0] rval;
		logic       last;
	} strip_word_t;

	class frame_scoreboard;
		logic [7:0]  led_mask;
		lmf_cfg_t    colors;
		strip_word_t pending[$];
		int          errors;

		function new();
			led_mask          = '0;
			colors.brightness = 5'd20;
			colors.blue       = 8'd255;
			colors.green      = 8'd0;
			colors.red        = 8'd0;
			errors            = 0;
		endfunction

		function void set_color(logic [1:0] idx, logic [7:0] value);
			case (idx)
			REG_BRIGHTNESS: colors.brightness = value[4:0];
			REG_BLUE:       colors.blue = value;
			REG_GREEN:      colors.green = value;
			default:        colors.red = value;
			endcase
		endfunction

		function logic [31:0] color_reg(logic [1:0] idx);
			case (idx)
			REG_BRIGHTNESS: return {27'b0, colors.brightness};
			REG_BLUE:       return {24'b0, colors.blue};
			REG_GREEN:      return {24'b0, colors.green};
			default:        return {24'b0, colors.red};
			endcase
		endfunction

		function void push_frame(logic [7:0] mask);
			logic [7:0]  seq[$];
			strip_word_t w;
			int          n;
			repeat (START_BYTES) seq.push_back(8'h00);
			for (int i = STRIP_LEDS - 1; i >= 0; i--) begin
				if (mask[i]) begin
					seq.push_back(LED_HEADER | {3'b0, colors.brightness});
					seq.push_back(colors.blue);
					seq.push_back(colors.green);
					seq.push_back(colors.red);
				end else begin
					seq.push_back(LED_HEADER);
					repeat (3) seq.push_back(8'h00);
				end
			end
			repeat (TAIL_BYTES) seq.push_back(END_BYTE);
			n = (seq.size() < MAX_RESULTS) ? seq.size() : MAX_RESULTS;
			for (int i = 0; i < n; i++) begin
				w.frame = 1'b1;
				w.fbyte = seq[i];
				w.rval  = 8'h00;
				w.last  = (i == n - 1);
				pending.push_back(w);
			end
		endfunction

		function void note_access(logic [1:0] f, logic [3:0] sel, logic [7:0] data);
			strip_word_t w;
			case (f)
			FUNC_READ: begin
				w      = '0;
				w.last = 1'b1;
				if (sel == 0)
					w.rval = led_mask;
				else if (sel <= 8)
					w.rval = {7'b0, led_mask[sel - 1]};
				pending.push_back(w);
			end
			FUNC_WRITE: begin
				if (sel == 0)
					led_mask = data;
				else if (sel <= 8) begin
					if (data == SET_CODE)
						led_mask[sel - 1] = 1'b1;
					else
						led_mask[sel - 1] = ~led_mask[sel - 1];
				end
				push_frame(led_mask);
			end
			FUNC_BLANK: push_frame(8'h00);
			default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic frame, logic [7:0] fb, logic [7:0] rv, logic lst);
			strip_word_t w;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer frame=%0b byte=%02h value=%02h last=%0b",
					frame, fb, rv, lst));
				return;
			end
			w = pending.pop_front();
			if (frame !== w.frame)
				report_mismatch($sformatf("is_frame_byte %0b, want %0b", frame, w.frame));
			if (fb !== w.fbyte)
				report_mismatch($sformatf("frame_byte %02h, want %02h", fb, w.fbyte));
			if (rv !== w.rval)
				report_mismatch($sformatf("read_value %02h, want %02h", rv, w.rval));
			if (lst !== w.last)
				report_mismatch($sformatf("last %0b, want %0b", lst, w.last));
		endtask
	endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the led mask framer. Directed accesses cover mask reads,
// set, toggle and whole-mask writes, selects past the strip, blank frames and
// the unused function code; random accesses then run under several lit colors,
// the extremes among them, with random gaps on both channels in all but one phase.
// ----------------------------------------------------------------------------
module tb_top;

	import lmf_pkg::*;
	import lmf_tb_pkg::*;

	localparam int SETTLE_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FUNC_READ;
	logic [3:0]  led_select = '0;
	logic [7:0]  write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_frame_byte;
	logic [7:0]  frame_byte;
	logic [7:0]  read_value;
	logic        last;

	bit              gaps_on = 1'b1;
	frame_scoreboard sb = new();

	led_mask_apa102_framer #(
		.LED_COUNT(STRIP_LEDS),
		.END_BYTES(TAIL_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.led_select(led_select),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_frame_byte(is_frame_byte),
		.frame_byte(frame_byte),
		.read_value(read_value),
		.last(last)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= arst_n && gaps_on && ($urandom_range(99) < 6);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(is_frame_byte, frame_byte, read_value, last);
	end

	task write_color(logic [1:0] idx, logic [7:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'b0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_color(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.color_reg(idx))
			sb.report_mismatch($sformatf("register %0d reads %08h, want %08h",
				idx, prdata, sb.color_reg(idx)));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task send_access(logic [1:0] f, logic [3:0] sel, logic [7:0] data);
		if (gaps_on && $urandom_range(99) < 6) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		func       <= f;
		led_select <= sel;
		write_data <= data;
		do @(posedge clk); while (in_stall);
		sb.note_access(f, sel, data);
	endtask

	task wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task random_access(output bit counted);
		logic [1:0] f;
		logic [3:0] sel;
		logic [7:0] data;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 45)
			f = FUNC_WRITE;
		else if (pick < 75)
			f = FUNC_READ;
		else if (pick < 92)
			f = FUNC_BLANK;
		else
			f = FUNC_UNUSED;
		sel  = ($urandom_range(99) < 12) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
		data = (sel != 0 && $urandom_range(1)) ? SET_CODE : 8'($urandom_range(255));
		send_access(f, sel, data);
		counted = (f != FUNC_UNUSED);
	endtask

	initial begin
		bit counted;
		int done;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed accesses under the reset colors
		send_access(FUNC_READ, 4'd0, 8'h00);
		send_access(FUNC_WRITE, 4'd0, 8'hA5);
		send_access(FUNC_READ, 4'd0, 8'h00);
		send_access(FUNC_READ, 4'd1, 8'h00);
		send_access(FUNC_READ, 4'd8, 8'h00);
		send_access(FUNC_READ, 4'd9, 8'h00);
		send_access(FUNC_READ, 4'd15, 8'hFF);
		send_access(FUNC_WRITE, 4'd2, SET_CODE);
		send_access(FUNC_WRITE, 4'd8, SET_CODE);
		send_access(FUNC_WRITE, 4'd3, 8'h00);
		send_access(FUNC_WRITE, 4'd3, 8'hFF);
		send_access(FUNC_WRITE, 4'd1, 8'h02);
		send_access(FUNC_WRITE, 4'd9, SET_CODE);
		send_access(FUNC_WRITE, 4'd15, 8'h00);
		send_access(FUNC_READ, 4'd0, 8'h00);
		send_access(FUNC_BLANK, 4'd0, 8'h00);
		send_access(FUNC_UNUSED, 4'd5, 8'h5A);
		send_access(FUNC_READ, 4'd0, 8'h00);
		send_access(FUNC_WRITE, 4'd0, 8'hFF);
		send_access(FUNC_BLANK, 4'd15, 8'hFF);
		send_access(FUNC_WRITE, 4'd0, 8'h00);
		send_access(FUNC_READ, 4'd8, 8'h00);

		for (int phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
			0: begin
				write_color(REG_BRIGHTNESS, 8'd0);
				write_color(REG_BLUE, 8'd0);
				write_color(REG_GREEN, 8'd0);
				write_color(REG_RED, 8'd0);
			end
			1: begin
				write_color(REG_BRIGHTNESS, 8'd31);
				write_color(REG_BLUE, 8'd255);
				write_color(REG_GREEN, 8'd255);
				write_color(REG_RED, 8'd255);
			end
			default: begin
				write_color(REG_BRIGHTNESS, 8'($urandom_range(31)));
				write_color(REG_BLUE, 8'($urandom_range(255)));
				write_color(REG_GREEN, 8'($urandom_range(255)));
				write_color(REG_RED, 8'($urandom_range(255)));
			end
			endcase
			gaps_on = (phase != 3);
			done = 0;
			while (done < 65) begin
				random_access(counted);
				if (counted)
					done++;
			end
		end
		gaps_on = 1'b1;

		wait_drained();
		if (sb.pending.size() != 0)
			sb.report_mismatch($sformatf("%0d transfers never arrived", sb.pending.size()));
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
design/lmf_pkg.sv
design/lmf_decode.sv
design/lmf_emitter.sv
design/led_mask_apa102_framer.sv
sim/lmf_tb_pkg.sv
sim/tb_top.sv
